@@ hdl/page_to_device_mapper_defines.svh @@
// Assertion shorthands shared by the RTL of the page mapper.
`ifndef PAGE_TO_DEVICE_MAPPER_DEFINES_SVH
`define PAGE_TO_DEVICE_MAPPER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define PTDM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define PTDM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ptdm_pkg.sv @@
package ptdm_pkg;

    localparam int MAX_DEVICES_DEF = 16;
    localparam int EXTENT_BITS_DEF = 24;

    localparam int ENTRY_INDEX_W = 4;
    localparam int ENTRY_W       = 24;
    localparam int PAGE_W        = 32;
    localparam int DEVICE_W      = 4;
    localparam int OFFSET_W      = 31;

    localparam int SIZE_W   = 16;
    localparam int TOTAL_W  = 24;
    localparam int COUNT_W  = 5;
    localparam int MASTER_W = 8;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [SIZE_W-1:0]   EXTENT_SIZE_RST    = 16'd1;
    localparam logic [TOTAL_W-1:0]  TOTAL_EXTENTS_RST  = 24'd0;
    localparam logic [COUNT_W-1:0]  DEVICE_COUNT_RST   = 5'd1;
    localparam logic                LOG_MODE_RST       = 1'b0;
    localparam logic [MASTER_W-1:0] MASTER_EXTENTS_RST = 8'd1;

    typedef enum logic [0:0] {
        OP_LOAD   = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_NO_DEVICE = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EXTENT_SIZE    = 3'd0,
        REG_TOTAL_EXTENTS  = 3'd1,
        REG_DEVICE_COUNT   = 3'd2,
        REG_LOG_MODE       = 3'd3,
        REG_MASTER_EXTENTS = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   extent_size;
        logic [TOTAL_W-1:0]  total_extents;
        logic [COUNT_W-1:0]  device_count;
        logic                log_mode;
        logic [MASTER_W-1:0] master_extents;
    } cfg_t;

    typedef struct packed {
        status_t              status;
        logic [DEVICE_W-1:0]  device_number;
        logic [OFFSET_W-1:0]  page_offset;
    } result_t;

    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ hdl/page_to_device_mapper.sv @@
// Channel  Direction  Transaction
// s_       in         one load or lookup item (tuser: opcode)
// m_       out        one result per item (tuser: status)
// cfg_     in         one register write (index, data)
//
// A load goes straight to its result; a lookup first forms the room and bound and checks the range.
// A lookup in range then runs search probes (up to log2(devices) + 1 probes), plus one more
// fetch of the upper bound's key without an exact key match; each probe is one table read with
// a registered result, a key correction and a key*extent_size multiply.
// One item is in flight; the next is taken once its result sits in the output register.
// aresetn is synchronous; the device table holds no reset value until loaded.
module page_to_device_mapper
    import ptdm_pkg::*;
#(
    parameter int MAX_DEVICES = MAX_DEVICES_DEF,
    parameter int EXTENT_BITS = EXTENT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] entry_index, [27:4] entry_first_extent, [59:28] page_number
    input  logic [63:0]            s_tdata,
    // [0] opcode
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [3:0] device_number, [34:4] page_offset
    output logic [39:0]            m_tdata,
    // [1:0] status
    output logic [1:0]             m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = addr_width(MAX_DEVICES);

    cfg_t                   cfg;
    logic                   tbl_wr_en;
    logic [ADDR_W-1:0]      tbl_wr_addr;
    logic [EXTENT_BITS-1:0] tbl_wr_data;
    logic                   tbl_rd_en;
    logic [ADDR_W-1:0]      tbl_rd_addr;
    logic [EXTENT_BITS-1:0] tbl_rd_data;
    logic                   res_valid;
    logic                   res_ready;
    result_t                res;

    logic                   m_tvalid_reg, m_tvalid_next;
    result_t                m_res_reg, m_res_next;

    ptdm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ptdm_table #(
        .MAX_DEVICES (MAX_DEVICES),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    ptdm_engine #(
        .MAX_DEVICES (MAX_DEVICES),
        .EXTENT_BITS (EXTENT_BITS)
    ) u_engine (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg                   (cfg),
        .in_valid              (s_tvalid),
        .in_ready              (s_tready),
        .in_opcode             (s_tuser[0]),
        .in_entry_index        (s_tdata[3:0]),
        .in_entry_first_extent (s_tdata[27:4]),
        .in_page_number        ($signed(s_tdata[59:28])),
        .tbl_wr_en             (tbl_wr_en),
        .tbl_wr_addr           (tbl_wr_addr),
        .tbl_wr_data           (tbl_wr_data),
        .tbl_rd_en             (tbl_rd_en),
        .tbl_rd_addr           (tbl_rd_addr),
        .tbl_rd_data           (tbl_rd_data),
        .res_valid             (res_valid),
        .res_ready             (res_ready),
        .res                   (res)
    );

    // Output register: take a new result whenever the current one leaves or none is held.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_res_next    = m_res_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                m_res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_res_reg.page_offset, m_res_reg.device_number};
    assign m_tuser  = m_res_reg.status;

endmodule

@@ hdl/ptdm_cfg.sv @@
module ptdm_cfg
    import ptdm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_EXTENT_SIZE:    cfg_next.extent_size    = cfg_data[SIZE_W-1:0];
                REG_TOTAL_EXTENTS:  cfg_next.total_extents  = cfg_data[TOTAL_W-1:0];
                REG_DEVICE_COUNT:   cfg_next.device_count   = cfg_data[COUNT_W-1:0];
                REG_LOG_MODE:       cfg_next.log_mode       = cfg_data[0];
                REG_MASTER_EXTENTS: cfg_next.master_extents = cfg_data[MASTER_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.extent_size    <= EXTENT_SIZE_RST;
            cfg_reg.total_extents  <= TOTAL_EXTENTS_RST;
            cfg_reg.device_count   <= DEVICE_COUNT_RST;
            cfg_reg.log_mode       <= LOG_MODE_RST;
            cfg_reg.master_extents <= MASTER_EXTENTS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/ptdm_table.sv @@
module ptdm_table
    import ptdm_pkg::*;
#(
    parameter  int MAX_DEVICES = MAX_DEVICES_DEF,
    parameter  int EXTENT_BITS = EXTENT_BITS_DEF,
    localparam int ADDR_W      = addr_width(MAX_DEVICES)
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  logic [EXTENT_BITS-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [ADDR_W-1:0]      rd_addr,
    output logic [EXTENT_BITS-1:0] rd_data
);

    logic [EXTENT_BITS-1:0] mem [MAX_DEVICES];
    logic [EXTENT_BITS-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/ptdm_engine.sv @@
`include "page_to_device_mapper_defines.svh"

module ptdm_engine
    import ptdm_pkg::*;
#(
    parameter  int MAX_DEVICES = MAX_DEVICES_DEF,
    parameter  int EXTENT_BITS = EXTENT_BITS_DEF,
    localparam int ADDR_W      = addr_width(MAX_DEVICES)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_opcode,
    input  logic [ENTRY_INDEX_W-1:0] in_entry_index,
    input  logic [ENTRY_W-1:0]       in_entry_first_extent,
    input  logic signed [PAGE_W-1:0] in_page_number,
    output logic                     tbl_wr_en,
    output logic [ADDR_W-1:0]        tbl_wr_addr,
    output logic [EXTENT_BITS-1:0]   tbl_wr_data,
    output logic                     tbl_rd_en,
    output logic [ADDR_W-1:0]        tbl_rd_addr,
    input  logic [EXTENT_BITS-1:0]   tbl_rd_data,
    output logic                     res_valid,
    input  logic                     res_ready,
    output result_t                  res
);

    localparam int CNT_W   = $clog2(MAX_DEVICES + 1);
    localparam int IDX_W   = CNT_W + 1;
    localparam int IM_W    = ADDR_W + MASTER_W;
    localparam int MN_W    = CNT_W + MASTER_W;
    localparam int MSZ_W   = MASTER_W + SIZE_W;
    localparam int ROOM_W  = TOTAL_W + 1;
    localparam int BOUND_W = TOTAL_W + SIZE_W;
    localparam int KEY_W   = ((EXTENT_BITS > IM_W) ? EXTENT_BITS : IM_W) + 1;
    localparam int PROD_W  = KEY_W + SIZE_W + 1;
    localparam int DIFF_W  = PROD_W + 1;
    localparam int OFF_W   = DIFF_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_ROOM,
        S_BOUND,
        S_CHECK,
        S_ADDR,
        S_KEY,
        S_MUL,
        S_CMP,
        S_OFF,
        S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic                       final_reg, final_next;
    logic signed [PAGE_W-1:0]   page_reg, page_next;
    logic [MN_W-1:0]            mn_reg, mn_next;
    logic [MSZ_W-1:0]           msz_reg, msz_next;
    logic signed [ROOM_W-1:0]   room_reg, room_next;
    logic [BOUND_W-1:0]         bound_reg, bound_next;
    logic signed [IDX_W-1:0]    lo_reg, lo_next;
    logic signed [IDX_W-1:0]    hi_reg, hi_next;
    logic [ADDR_W-1:0]          probe_reg, probe_next;
    logic [IM_W-1:0]            im_reg, im_next;
    logic signed [KEY_W-1:0]    key_reg, key_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    result_t                    res_reg, res_next;

    logic [CNT_W-1:0]           n_sat;
    logic [CNT_W-1:0]           n_less;
    logic signed [ROOM_W-1:0]   mn_sub;
    logic signed [KEY_W-1:0]    im_sub;
    logic signed [DIFF_W-1:0]   diff;
    logic                       diff_neg;
    logic                       diff_ge;
    logic                       hit;
    logic                       range_err;
    logic signed [IDX_W-1:0]    mid_s;
    logic signed [IDX_W-1:0]    lo_cand, hi_cand;
    logic signed [IDX_W:0]      span_sum;
    logic signed [OFF_W-1:0]    msz_add;
    logic signed [OFF_W-1:0]    off_full;
    logic [OFFSET_W-1:0]        off_clamped;

    always_comb begin
        if (32'(cfg.device_count) > MAX_DEVICES) begin
            n_sat = CNT_W'(MAX_DEVICES);
        end else begin
            n_sat = CNT_W'(cfg.device_count);
        end
    end

    assign n_less = n_sat - CNT_W'(1);

    assign mn_sub = cfg.log_mode ? $signed(ROOM_W'(mn_reg)) : '0;
    assign im_sub = cfg.log_mode ? $signed(KEY_W'(im_reg)) : '0;

    assign range_err = (room_reg <= 0) || (page_reg < 0)
                       || (BOUND_W'(page_reg[PAGE_W-2:0]) >= bound_reg);

    // Compare key*size against the page instead of dividing the page by the size.
    assign diff     = $signed(DIFF_W'(page_reg[PAGE_W-2:0])) - DIFF_W'(prod_reg);
    assign diff_neg = diff[DIFF_W-1];
    assign diff_ge  = diff >= $signed(DIFF_W'(cfg.extent_size));
    assign hit      = !diff_neg && !diff_ge;

    assign mid_s = $signed(IDX_W'(probe_reg));

    always_comb begin
        if (diff_neg) begin
            lo_cand = lo_reg;
            hi_cand = mid_s - $signed(IDX_W'(1));
        end else begin
            lo_cand = mid_s + $signed(IDX_W'(1));
            hi_cand = hi_reg;
        end
    end

    assign span_sum = (IDX_W + 1)'(lo_cand) + (IDX_W + 1)'(hi_cand);

    assign msz_add  = cfg.log_mode ? $signed(OFF_W'(msz_reg)) : '0;
    assign off_full = OFF_W'(diff) + msz_add;

    always_comb begin
        if (off_full[OFF_W-1]) begin
            off_clamped = '0;
        end else if (|off_full[OFF_W-2:OFFSET_W]) begin
            off_clamped = '1;
        end else begin
            off_clamped = off_full[OFFSET_W-1:0];
        end
    end

    // Table writes happen only when idle and reads only while busy, so the two ports
    // never touch the same entry in one cycle.
    assign in_ready    = (state_reg == S_IDLE);
    assign tbl_wr_en   = in_ready && in_valid && (in_opcode == OP_LOAD)
                         && (32'(in_entry_index) < MAX_DEVICES);
    assign tbl_wr_addr = ADDR_W'(in_entry_index);
    assign tbl_wr_data = EXTENT_BITS'(in_entry_first_extent);
    assign tbl_rd_en   = (state_reg == S_ADDR);
    assign tbl_rd_addr = probe_reg;
    assign res_valid   = (state_reg == S_DONE);
    assign res         = res_reg;

    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        page_next  = page_reg;
        mn_next    = mn_reg;
        msz_next   = msz_reg;
        room_next  = room_reg;
        bound_next = bound_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        probe_next = probe_reg;
        im_next    = im_reg;
        key_next   = key_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (in_opcode == OP_LOAD) begin
                        res_next   = '{status: ST_OK, device_number: '0, page_offset: '0};
                        state_next = S_DONE;
                    end else begin
                        page_next  = in_page_number;
                        state_next = S_MUL0;
                    end
                end
            end
            S_MUL0: begin
                mn_next    = MN_W'(cfg.master_extents) * MN_W'(n_sat);
                msz_next   = MSZ_W'(cfg.master_extents) * MSZ_W'(cfg.extent_size);
                state_next = S_ROOM;
            end
            S_ROOM: begin
                room_next  = $signed(ROOM_W'(cfg.total_extents)) - mn_sub;
                state_next = S_BOUND;
            end
            S_BOUND: begin
                bound_next = BOUND_W'(room_reg[TOTAL_W-1:0]) * BOUND_W'(cfg.extent_size);
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (range_err) begin
                    res_next   = '{status: ST_RANGE, device_number: '0, page_offset: '0};
                    state_next = S_DONE;
                end else if (n_sat == '0) begin
                    res_next   = '{status: ST_NO_DEVICE, device_number: '0, page_offset: '0};
                    state_next = S_DONE;
                end else begin
                    lo_next    = '0;
                    hi_next    = $signed(IDX_W'(n_less));
                    probe_next = ADDR_W'(n_less >> 1);
                    final_next = 1'b0;
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                im_next    = IM_W'(probe_reg) * IM_W'(cfg.master_extents);
                state_next = S_KEY;
            end
            S_KEY: begin
                key_next   = $signed(KEY_W'(tbl_rd_data)) - im_sub;
                state_next = S_MUL;
            end
            S_MUL: begin
                prod_next  = key_reg * $signed({1'b0, cfg.extent_size});
                state_next = final_reg ? S_OFF : S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    state_next = S_OFF;
                end else if (lo_cand <= hi_cand) begin
                    lo_next    = lo_cand;
                    hi_next    = hi_cand;
                    probe_next = span_sum[ADDR_W:1];
                    state_next = S_ADDR;
                end else if (hi_cand[IDX_W-1]) begin
                    res_next   = '{status: ST_NO_DEVICE, device_number: '0, page_offset: '0};
                    state_next = S_DONE;
                end else begin
                    // No exact hit: settle on the upper bound and fetch its key once more.
                    lo_next    = lo_cand;
                    hi_next    = hi_cand;
                    probe_next = hi_cand[ADDR_W-1:0];
                    final_next = 1'b1;
                    state_next = S_ADDR;
                end
            end
            S_OFF: begin
                res_next   = '{status: ST_OK, device_number: DEVICE_W'(probe_reg),
                               page_offset: off_clamped};
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
        page_reg  <= page_next;
        mn_reg    <= mn_next;
        msz_reg   <= msz_next;
        room_reg  <= room_next;
        bound_reg <= bound_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        probe_reg <= probe_next;
        im_reg    <= im_next;
        key_reg   <= key_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
    end

    `PTDM_ASSERT_IMP(a_cmp_span, aclk, aresetn, state_reg == S_CMP, lo_reg <= hi_reg, "search range empty at compare")
    `PTDM_ASSERT_IMP(a_probe_in_span, aclk, aresetn, (state_reg == S_ADDR) && !final_reg, (mid_s >= lo_reg) && (mid_s <= hi_reg), "probe outside search range")
    `PTDM_ASSERT_NXT(a_lookup_start, aclk, aresetn, in_valid && in_ready && (in_opcode == OP_LOOKUP), state_reg == S_MUL0, "lookup did not start")
    `PTDM_ASSERT_IMP(a_err_zero, aclk, aresetn, res_valid && (res_reg.status != ST_OK), (res_reg.device_number == '0) && (res_reg.page_offset == '0), "error result carries data")
    `PTDM_ASSERT_NXT(a_res_hold, aclk, aresetn, res_valid && !res_ready, res_valid && $stable(res_reg), "pending result lost")

endmodule
